>>> design/dtfa_pkg.sv
// Package for the date and time field adjuster.
// Holds the request codes, event codes, reset values and calendar helpers.
// Depends on nothing; every other design file imports it.
package dtfa_pkg;

   // Request kinds
   typedef enum logic [4:0] {
      KIND_YEAR_UP    = 5'd0,
      KIND_YEAR_DN    = 5'd1,
      KIND_MONTH_UP   = 5'd2,
      KIND_MONTH_DN   = 5'd3,
      KIND_DAY_UP     = 5'd4,
      KIND_DAY_DN     = 5'd5,
      KIND_HOUR_UP    = 5'd6,
      KIND_HOUR_DN    = 5'd7,
      KIND_HOUR_ZERO  = 5'd8,
      KIND_MIN_UP     = 5'd9,
      KIND_MIN_DN     = 5'd10,
      KIND_MIN_ZERO   = 5'd11,
      KIND_SEC_UP     = 5'd12,
      KIND_SEC_DN     = 5'd13,
      KIND_SEC_ZERO   = 5'd14,
      KIND_OTHER      = 5'd15,
      KIND_LOAD       = 5'd16
   } kind_type;

   // Event codes reported with each result
   typedef enum logic [1:0] {
      EVT_UPDATE = 2'd0,
      EVT_CHANGE = 2'd1,
      EVT_LOADED = 2'd2
   } evt_type;

   // Register indexes on the CSR port
   localparam logic CSR_YEAR_LO = 1'b0;
   localparam logic CSR_YEAR_HI = 1'b1;

   // Field widths
   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MS_W    = 6;

   // Reset values
   localparam logic [YEAR_W-1:0] YEAR_LO_RST = 14'd1900;
   localparam logic [YEAR_W-1:0] YEAR_HI_RST = 14'd2100;

   // Field tops
   localparam logic [MONTH_W:0] MONTH_TOP = 5'd12;
   localparam logic [HOUR_W:0]  HOUR_TOP  = 6'd23;
   localparam logic [MS_W:0]    MS_TOP    = 7'd59;

   // Divisible-by-25 test: multiply by the inverse of 25 modulo 2^14, then
   // multiples of 25 land exactly on 0..655.
   localparam logic [YEAR_W-1:0] INV_25     = 14'd7209;
   localparam logic [YEAR_W-1:0] DIV25_LIMIT = 14'd655;

   // Month length, invalid months count as 31, February as 28
   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m);
      logic [DAY_W-1:0] d;
      unique case (m)
         4'd2:                   d = 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
         default:                d = 5'd31;
      endcase
      return d;
   endfunction

endpackage

>>> design/dtfa_if.sv
// Channel interfaces for the date and time field adjuster.
// Request and result channels with valid/ready handshake; uses dtfa_pkg.
interface dtfa_req_if import dtfa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [4:0]        kind;
   logic [YEAR_W-1:0] load_year;
   logic [MONTH_W-1:0] load_month;
   logic [DAY_W-1:0]  load_day;
   logic [HOUR_W-1:0] load_hour;
   logic [MS_W-1:0]   load_minute;
   logic [MS_W-1:0]   load_second;

   modport source (output valid, kind, load_year, load_month, load_day, load_hour,
                   load_minute, load_second, input ready);
   modport sink   (input valid, kind, load_year, load_month, load_day, load_hour,
                   load_minute, load_second, output ready);
endinterface

interface dtfa_rsp_if import dtfa_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [YEAR_W-1:0]  year;
   logic [MONTH_W-1:0] month;
   logic [DAY_W-1:0]   day;
   logic [HOUR_W-1:0]  hour;
   logic [MS_W-1:0]    minute;
   logic [MS_W-1:0]    second;
   logic [1:0]         event_res;

   modport source (output valid, year, month, day, hour, minute, second, event_res,
                   input ready);
   modport sink   (input valid, year, month, day, hour, minute, second, event_res,
                   output ready);
endinterface

>>> design/date_time_field_adjuster.sv
// Top level of the date and time field adjuster.
// Uses dtfa_pkg and the channel interfaces in dtfa_if.sv.
//
// Usage: each request on req_ch is one button action (step a field up or
// down, or zero hour, minute or second) or a load of all six fields. Each
// request gives exactly one result on rsp_ch: the six fields after the
// action and an event code (update, change for an unknown kind, loaded).
// The lower and upper year bounds are to be written by the user on the CSR port only
// while the block idles; the block itself does not enforce this. A request is held
// in the input register, then its result is registered in the field registers.
// Throughput: one request per cycle while rsp_ch does not stall; the field update,
// including the leap year test of one 14-bit constant multiply, fits between the
// input register and the field registers.
// The field registers double as the result register, so a result holds
// while rsp_ch stalls; one more request may wait in the input register,
// after which req_ch.ready drops.
// Reset (synchronous): year bounds 1900 and 2100, date 1900-01-01,
// time 00:00:00, both stages empty.
module date_time_field_adjuster import dtfa_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   dtfa_req_if.sink          req_ch,
   dtfa_rsp_if.source        rsp_ch,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [YEAR_W-1:0] csr_wdata
);

   // Configuration registers
   logic [YEAR_W-1:0] year_lo_ff, year_hi_ff;

   // Input stage
   logic               in_valid_ff;
   kind_type           kind_ff;
   logic [YEAR_W-1:0]  ld_year_ff;
   logic [MONTH_W-1:0] ld_month_ff;
   logic [DAY_W-1:0]   ld_day_ff;
   logic [HOUR_W-1:0]  ld_hour_ff;
   logic [MS_W-1:0]    ld_minute_ff, ld_second_ff;

   // Field state, also the result register
   logic               out_valid_ff;
   logic [YEAR_W-1:0]  year_ff, year_in;
   logic [MONTH_W-1:0] month_ff, month_in;
   logic [DAY_W-1:0]   day_ff, day_in;
   logic [HOUR_W-1:0]  hour_ff, hour_in;
   logic [MS_W-1:0]    minute_ff, minute_in;
   logic [MS_W-1:0]    second_ff, second_in;
   evt_type            evt_ff, evt_in;

   logic advance;
   logic req_take;

   // Move the input stage on when the result slot is free or being taken
   assign advance  = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_take = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         year_lo_ff <= YEAR_LO_RST;
         year_hi_ff <= YEAR_HI_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_YEAR_LO: year_lo_ff <= csr_wdata;
            CSR_YEAR_HI: year_hi_ff <= csr_wdata;
            default:     ;
         endcase
      end
   end

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ch.ready) begin
         in_valid_ff <= req_ch.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         kind_ff      <= kind_type'(req_ch.kind);
         ld_year_ff   <= req_ch.load_year;
         ld_month_ff  <= req_ch.load_month;
         ld_day_ff    <= req_ch.load_day;
         ld_hour_ff   <= req_ch.load_hour;
         ld_minute_ff <= req_ch.load_minute;
         ld_second_ff <= req_ch.load_second;
      end
   end

   // Leap year test of the stored year
   logic [YEAR_W-1:0] y_mul25;
   logic              div25;
   logic              leap;
   logic [DAY_W-1:0]  dim;

   always_comb begin
      y_mul25 = YEAR_W'(year_ff * INV_25);
      div25   = (y_mul25 <= DIV25_LIMIT);
      leap    = (year_ff[1:0] == 2'd0) && (!div25 || (year_ff[3:0] == 4'd0));
      dim     = (month_ff == 4'd2 && leap) ? 5'd29 : month_len(month_ff);
   end

   // Stepped values of each field
   logic [YEAR_W:0]  year_inc;
   logic [YEAR_W-1:0] year_up, year_dn;
   logic [MONTH_W:0] month_inc;
   logic [MONTH_W-1:0] month_up, month_dn;
   logic [DAY_W:0]   day_inc;
   logic [DAY_W-1:0] day_up, day_dn;
   logic [HOUR_W:0]  hour_inc;
   logic [HOUR_W-1:0] hour_up, hour_dn;
   logic [MS_W:0]    minute_inc, second_inc;
   logic [MS_W-1:0]  minute_up, minute_dn, second_up, second_dn;

   always_comb begin
      year_inc = {1'b0, year_ff} + 1'b1;
      year_up  = (year_inc > {1'b0, year_hi_ff}) ? year_lo_ff : year_inc[YEAR_W-1:0];
      year_dn  = (year_ff == '0 || (year_ff - 1'b1) < year_lo_ff)
                 ? year_lo_ff : year_ff - 1'b1;

      month_inc = {1'b0, month_ff} + 1'b1;
      month_up  = (month_inc > MONTH_TOP) ? 4'd1 : month_inc[MONTH_W-1:0];
      month_dn  = (month_ff <= 4'd1) ? MONTH_TOP[MONTH_W-1:0] : month_ff - 1'b1;

      day_inc = {1'b0, day_ff} + 1'b1;
      day_up  = (day_inc > {1'b0, dim}) ? 5'd1 : day_inc[DAY_W-1:0];
      day_dn  = (day_ff <= 5'd1) ? dim : day_ff - 1'b1;

      hour_inc = {1'b0, hour_ff} + 1'b1;
      hour_up  = (hour_inc > HOUR_TOP) ? '0 : hour_inc[HOUR_W-1:0];
      hour_dn  = (hour_ff == '0) ? HOUR_TOP[HOUR_W-1:0] : hour_ff - 1'b1;

      minute_inc = {1'b0, minute_ff} + 1'b1;
      minute_up  = (minute_inc > MS_TOP) ? '0 : minute_inc[MS_W-1:0];
      minute_dn  = (minute_ff == '0) ? MS_TOP[MS_W-1:0] : minute_ff - 1'b1;

      second_inc = {1'b0, second_ff} + 1'b1;
      second_up  = (second_inc > MS_TOP) ? '0 : second_inc[MS_W-1:0];
      second_dn  = (second_ff == '0) ? MS_TOP[MS_W-1:0] : second_ff - 1'b1;
   end

   // Select the field that the request touches
   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_in    = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      second_in = second_ff;
      evt_in    = EVT_UPDATE;
      unique case (kind_ff)
         KIND_YEAR_UP:   year_in   = year_up;
         KIND_YEAR_DN:   year_in   = year_dn;
         KIND_MONTH_UP:  month_in  = month_up;
         KIND_MONTH_DN:  month_in  = month_dn;
         KIND_DAY_UP:    day_in    = day_up;
         KIND_DAY_DN:    day_in    = day_dn;
         KIND_HOUR_UP:   hour_in   = hour_up;
         KIND_HOUR_DN:   hour_in   = hour_dn;
         KIND_HOUR_ZERO: hour_in   = '0;
         KIND_MIN_UP:    minute_in = minute_up;
         KIND_MIN_DN:    minute_in = minute_dn;
         KIND_MIN_ZERO:  minute_in = '0;
         KIND_SEC_UP:    second_in = second_up;
         KIND_SEC_DN:    second_in = second_dn;
         KIND_SEC_ZERO:  second_in = '0;
         KIND_LOAD: begin
            year_in   = ld_year_ff;
            month_in  = ld_month_ff;
            day_in    = ld_day_ff;
            hour_in   = ld_hour_ff;
            minute_in = ld_minute_ff;
            second_in = ld_second_ff;
            evt_in    = EVT_LOADED;
         end
         default:        evt_in    = EVT_CHANGE;
      endcase
   end

   // Field state and result valid
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         year_ff      <= YEAR_LO_RST;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= '0;
         minute_ff    <= '0;
         second_ff    <= '0;
         evt_ff       <= EVT_UPDATE;
      end else begin
         if (advance) begin
            out_valid_ff <= 1'b1;
            year_ff      <= year_in;
            month_ff     <= month_in;
            day_ff       <= day_in;
            hour_ff      <= hour_in;
            minute_ff    <= minute_in;
            second_ff    <= second_in;
            evt_ff       <= evt_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // Drive the result channel
   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.year      = year_ff;
   assign rsp_ch.month     = month_ff;
   assign rsp_ch.day       = day_ff;
   assign rsp_ch.hour      = hour_ff;
   assign rsp_ch.minute    = minute_ff;
   assign rsp_ch.second    = second_ff;
   assign rsp_ch.event_res = evt_ff;

   // Both stages empty straight after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!out_valid_ff && !in_valid_ff))
      else $error("stages not empty after reset");

   // A request that moves on always produces a result
   a_advance_result: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("advanced request gave no result");

   // A load stores its year and second and reports loaded
   a_load_fields: assert property (@(posedge clock) disable iff (reset)
      (advance && kind_ff == KIND_LOAD) |=>
         (year_ff == $past(ld_year_ff) && second_ff == $past(ld_second_ff)
          && evt_ff == EVT_LOADED))
      else $error("load not stored");

   // An unknown kind leaves every field alone
   a_unknown_hold: assert property (@(posedge clock) disable iff (reset)
      (advance && evt_in == EVT_CHANGE) |=>
         ($stable(year_ff) && $stable(month_ff) && $stable(day_ff)
          && $stable(hour_ff) && $stable(minute_ff) && $stable(second_ff)))
      else $error("unknown kind changed a field");

endmodule

>>> tb/tb_date_time_field_adjuster.sv
// Self-checking testbench for the date and time field adjuster: directed table, then
// random requests under several year bounds, results checked against table or predictor.
// Depends on dtfa_pkg, the channel interfaces in dtfa_if.sv and date_time_field_adjuster.
module tb_date_time_field_adjuster;
   timeunit 1ns;
   timeprecision 1ps;

   import dtfa_pkg::*;

   // Kinds outside the package list, all reported as a change
   localparam logic [4:0] KIND_SPARE_FIRST = 5'd17;
   localparam logic [4:0] KIND_SPARE_LAST  = 5'd31;

   localparam int MONTHS_PER_YEAR = 12;
   localparam int LAST_HOUR       = 23;
   localparam int LAST_MIN_SEC    = 59;
   localparam int FLOOR_AT_RESET  = 1900;
   localparam int CEIL_AT_RESET   = 2100;

   localparam int RAND_PER_PHASE  = 75;
   localparam int NUM_PHASES      = 7;
   localparam int PRESSURE_PHASE  = 2;
   localparam int BURST_REQUESTS  = 12;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int SETTLE_CYCLES   = 4;
   localparam int STALL_LIMIT     = 1000;

   typedef struct packed {
      logic [YEAR_W-1:0]  year;
      logic [MONTH_W-1:0] month;
      logic [DAY_W-1:0]   day;
      logic [HOUR_W-1:0]  hour;
      logic [MS_W-1:0]    minute;
      logic [MS_W-1:0]    second;
   } stamp_type;

   typedef struct packed {
      stamp_type at;
      evt_type   ev;
   } outcome_type;

   typedef struct packed {
      logic [4:0] kind;
      stamp_type  load;
   } button_req_type;

   typedef struct packed {
      button_req_type req;
      logic           typed;
      outcome_type    want;
   } script_row_type;

   logic              clock;
   logic              reset;
   logic              csr_we;
   logic              csr_index;
   logic [YEAR_W-1:0] csr_wdata;

   dtfa_req_if req_ch ();
   dtfa_rsp_if rsp_ch ();

   date_time_field_adjuster uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Predicted calendar state and year bounds
   stamp_type         cal_now;
   logic [YEAR_W-1:0] year_floor;
   logic [YEAR_W-1:0] year_ceiling;

   outcome_type    pending_outcomes[$];
   script_row_type script[$];
   int             mismatches;
   int             idle_cycles = 0;
   bit             sender_idles;
   bit             receiver_idles;
   bit             hold_off_req;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic stamp_type stamp(int y, int mo, int d, int h, int mi, int s);
      stamp_type t;
      t.year   = YEAR_W'(y);
      t.month  = MONTH_W'(mo);
      t.day    = DAY_W'(d);
      t.hour   = HOUR_W'(h);
      t.minute = MS_W'(mi);
      t.second = MS_W'(s);
      return t;
   endfunction

   function automatic bit leap_year(int y);
      return (y % 4 == 0 && y % 100 != 0) || y % 400 == 0;
   endfunction

   // Month length; months outside 1..12 count as 31
   function automatic int days_in(int y, int m);
      int d;
      case (m)
         2:            d = leap_year(y) ? 29 : 28;
         4, 6, 9, 11:  d = 30;
         default:      d = 31;
      endcase
      return d;
   endfunction

   function automatic int wrap_up(int v, int top, int bottom);
      return (v + 1 > top) ? bottom : v + 1;
   endfunction

   function automatic int wrap_down(int v, int top, int bottom);
      return (v <= bottom) ? top : v - 1;
   endfunction

   // Apply one request to the predicted state and return the result it gives
   function automatic outcome_type advance_calendar(button_req_type r);
      outcome_type o;
      int          y;
      int          lo;
      int          hi;
      y  = int'(cal_now.year);
      lo = int'(year_floor);
      hi = int'(year_ceiling);
      o.ev = EVT_UPDATE;
      case (r.kind)
         KIND_YEAR_UP:   cal_now.year = YEAR_W'((y + 1 > hi) ? lo : y + 1);
         KIND_YEAR_DN:   cal_now.year = YEAR_W'((y == 0 || y - 1 < lo) ? lo : y - 1);
         KIND_MONTH_UP:  cal_now.month = MONTH_W'(wrap_up(int'(cal_now.month),
                                                          MONTHS_PER_YEAR, 1));
         KIND_MONTH_DN:  cal_now.month = MONTH_W'(wrap_down(int'(cal_now.month),
                                                            MONTHS_PER_YEAR, 1));
         KIND_DAY_UP:    cal_now.day = DAY_W'(wrap_up(int'(cal_now.day),
                                                      days_in(y, int'(cal_now.month)), 1));
         KIND_DAY_DN:    cal_now.day = DAY_W'(wrap_down(int'(cal_now.day),
                                                        days_in(y, int'(cal_now.month)), 1));
         KIND_HOUR_UP:   cal_now.hour = HOUR_W'(wrap_up(int'(cal_now.hour), LAST_HOUR, 0));
         KIND_HOUR_DN:   cal_now.hour = HOUR_W'(wrap_down(int'(cal_now.hour), LAST_HOUR, 0));
         KIND_HOUR_ZERO: cal_now.hour = '0;
         KIND_MIN_UP:    cal_now.minute = MS_W'(wrap_up(int'(cal_now.minute), LAST_MIN_SEC, 0));
         KIND_MIN_DN:    cal_now.minute = MS_W'(wrap_down(int'(cal_now.minute), LAST_MIN_SEC, 0));
         KIND_MIN_ZERO:  cal_now.minute = '0;
         KIND_SEC_UP:    cal_now.second = MS_W'(wrap_up(int'(cal_now.second), LAST_MIN_SEC, 0));
         KIND_SEC_DN:    cal_now.second = MS_W'(wrap_down(int'(cal_now.second), LAST_MIN_SEC, 0));
         KIND_SEC_ZERO:  cal_now.second = '0;
         KIND_LOAD: begin
            cal_now = r.load;
            o.ev    = EVT_LOADED;
         end
         default:        o.ev = EVT_CHANGE;
      endcase
      o.at = cal_now;
      return o;
   endfunction

   function automatic void add_row(logic [4:0] k, stamp_type ld, logic typed, stamp_type at,
                                   evt_type ev);
      script_row_type row;
      row.req.kind = k;
      row.req.load = ld;
      row.typed    = typed;
      row.want.at  = at;
      row.want.ev  = ev;
      script.push_back(row);
   endfunction

   // Years near the bounds, leap corner cases, or anywhere in range
   function automatic int pick_year();
      int y;
      case ($urandom_range(0, 5))
         0: y = int'(year_floor) + int'($urandom_range(0, 2)) - 1;
         1: y = int'(year_ceiling) + int'($urandom_range(0, 2)) - 1;
         2: begin
            case ($urandom_range(0, 3))
               0:       y = 0;
               1:       y = 1900;
               2:       y = 2000;
               default: y = 4 * int'($urandom_range(0, 2499));
            endcase
         end
         default: y = int'($urandom_range(0, 9999));
      endcase
      return y;
   endfunction

   function automatic button_req_type random_request();
      button_req_type r;
      int             pick;
      int             d;
      r.load = stamp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
         r.kind = KIND_LOAD;
         // mostly calendar dates, the rest raw random bits that may lie past every range
         if (pick >= 4) begin
            d = $urandom_range(0, 1) ? $urandom_range(27, 31) : $urandom_range(1, 31);
            r.load = stamp(pick_year(), $urandom_range(1, MONTHS_PER_YEAR), d,
                           $urandom_range(0, LAST_HOUR), $urandom_range(0, LAST_MIN_SEC),
                           $urandom_range(0, LAST_MIN_SEC));
         end
      end else if (pick == 15) begin
         r.kind = KIND_OTHER;
      end else if (pick < 20) begin
         r.kind = 5'($urandom_range(KIND_SPARE_FIRST, KIND_SPARE_LAST));
      end else begin
         r.kind = 5'($urandom_range(KIND_YEAR_UP, KIND_SEC_ZERO));
      end
      return r;
   endfunction

   // After an optional pause, offer one request, hold it until taken, then log what it should give
   task automatic offer_request(button_req_type r, logic typed, outcome_type want,
                                bit may_pause);
      outcome_type o;
      if (may_pause && sender_idles && $urandom_range(0, 4) == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.kind        <= r.kind;
      req_ch.load_year   <= r.load.year;
      req_ch.load_month  <= r.load.month;
      req_ch.load_day    <= r.load.day;
      req_ch.load_hour   <= r.load.hour;
      req_ch.load_minute <= r.load.minute;
      req_ch.load_second <= r.load.second;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      o = advance_calendar(r);
      pending_outcomes.push_back(typed ? want : o);
   endtask

   task automatic write_csr(logic idx, logic [YEAR_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_YEAR_LO) begin
         year_floor = value;
      end else begin
         year_ceiling = value;
      end
   endtask

   // Drop valid, wait for every result, then let the pipeline settle
   task automatic drain_results();
      req_ch.valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d, actual %0d", $time, what, want, got);
         mismatches++;
      end
   endfunction

   // Compare each accepted result with the oldest pending one
   always @(posedge clock) begin : check_results
      outcome_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (pending_outcomes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %0d-%0d-%0d event %0d",
                     $time, rsp_ch.year, rsp_ch.month, rsp_ch.day, rsp_ch.event_res);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            check_field("year", 16'(want.at.year), 16'(rsp_ch.year));
            check_field("month", 16'(want.at.month), 16'(rsp_ch.month));
            check_field("day", 16'(want.at.day), 16'(rsp_ch.day));
            check_field("hour", 16'(want.at.hour), 16'(rsp_ch.hour));
            check_field("minute", 16'(want.at.minute), 16'(rsp_ch.minute));
            check_field("second", 16'(want.at.second), 16'(rsp_ch.second));
            check_field("event", 16'(want.ev), 16'(rsp_ch.event_res));
         end
      end
   end

   // Abort when neither channel moves for too long
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Result side: random stall bursts, plus one long hold-off on request
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (hold_off_req) begin
            hold_off_req = 1'b0;
            stall_left   = HOLD_OFF_CYCLES;
         end else if (receiver_idles && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(1, 14);
         end
         rsp_ch.ready <= (stall_left == 0);
      end
   end

   initial begin
      int lo;
      int hi;
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = CSR_YEAR_LO;
      csr_wdata          = '0;
      req_ch.valid       = 1'b0;
      req_ch.kind        = KIND_OTHER;
      req_ch.load_year   = '0;
      req_ch.load_month  = '0;
      req_ch.load_day    = '0;
      req_ch.load_hour   = '0;
      req_ch.load_minute = '0;
      req_ch.load_second = '0;
      mismatches     = 0;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      hold_off_req   = 1'b0;
      year_floor     = YEAR_W'(FLOOR_AT_RESET);
      year_ceiling   = YEAR_W'(CEIL_AT_RESET);
      cal_now        = stamp(FLOOR_AT_RESET, 1, 1, 0, 0, 0);

      // Directed table: reset state, every wrap, clamp, leap and raw load
      add_row(KIND_OTHER,     '1, 1, stamp(1900,  1,  1,  0,  0,  0), EVT_CHANGE);
      add_row(KIND_YEAR_DN,   '1, 1, stamp(1900,  1,  1,  0,  0,  0), EVT_UPDATE);
      add_row(KIND_HOUR_DN,   '1, 1, stamp(1900,  1,  1, 23,  0,  0), EVT_UPDATE);
      add_row(KIND_MIN_DN,    '1, 1, stamp(1900,  1,  1, 23, 59,  0), EVT_UPDATE);
      add_row(KIND_SEC_DN,    '1, 1, stamp(1900,  1,  1, 23, 59, 59), EVT_UPDATE);
      add_row(KIND_SEC_UP,    '1, 1, stamp(1900,  1,  1, 23, 59,  0), EVT_UPDATE);
      add_row(KIND_MIN_UP,    '1, 1, stamp(1900,  1,  1, 23,  0,  0), EVT_UPDATE);
      add_row(KIND_HOUR_UP,   '1, 1, stamp(1900,  1,  1,  0,  0,  0), EVT_UPDATE);
      add_row(KIND_DAY_DN,    '1, 1, stamp(1900,  1, 31,  0,  0,  0), EVT_UPDATE);
      add_row(KIND_MONTH_DN,  '1, 1, stamp(1900, 12, 31,  0,  0,  0), EVT_UPDATE);
      add_row(KIND_MONTH_UP,  '1, 1, stamp(1900,  1, 31,  0,  0,  0), EVT_UPDATE);
      add_row(KIND_LOAD, stamp(2100, 2, 28, 12, 34, 56),
              1, stamp(2100,  2, 28, 12, 34, 56), EVT_LOADED);
      add_row(KIND_YEAR_UP,   '1, 1, stamp(1900,  2, 28, 12, 34, 56), EVT_UPDATE);
      add_row(KIND_DAY_UP,    '1, 1, stamp(1900,  2,  1, 12, 34, 56), EVT_UPDATE);
      add_row(KIND_LOAD, stamp(2000, 2, 28, 23, 59, 59),
              1, stamp(2000,  2, 28, 23, 59, 59), EVT_LOADED);
      add_row(KIND_DAY_UP,    '1, 0, '0, EVT_UPDATE);
      add_row(KIND_DAY_UP,    '1, 0, '0, EVT_UPDATE);
      add_row(KIND_HOUR_ZERO, '1, 0, '0, EVT_UPDATE);
      add_row(KIND_MIN_ZERO,  '1, 0, '0, EVT_UPDATE);
      add_row(KIND_SEC_ZERO,  '1, 0, '0, EVT_UPDATE);
      add_row(KIND_LOAD, '1, 1, '1, EVT_LOADED);
      add_row(KIND_DAY_UP,    '0, 0, '0, EVT_UPDATE);
      add_row(KIND_MONTH_UP,  '0, 0, '0, EVT_UPDATE);
      add_row(KIND_HOUR_UP,   '0, 0, '0, EVT_UPDATE);
      add_row(KIND_MIN_DN,    '0, 0, '0, EVT_UPDATE);
      add_row(KIND_YEAR_DN,   '0, 0, '0, EVT_UPDATE);
      add_row(KIND_SPARE_LAST,  '1, 0, '0, EVT_UPDATE);
      add_row(KIND_SPARE_FIRST, '0, 0, '0, EVT_UPDATE);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (script[i]) begin
         offer_request(script[i].req, script[i].typed, script[i].want, 1'b1);
      end
      drain_results();

      // Random phases, each under its own year bounds
      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         case (ph)
            0: begin lo = 0;    hi = 9999; end
            1: begin lo = 1990; hi = 2010; end
            2: begin lo = 2000; hi = 1990; end
            3: begin lo = 9999; hi = 9999; end
            4: begin lo = 0;    hi = 0;    end
            5: begin
               lo = $urandom_range(0, 9999);
               hi = $urandom_range(lo, 9999);
            end
            default: begin lo = FLOOR_AT_RESET; hi = CEIL_AT_RESET; end
         endcase
         write_csr(CSR_YEAR_LO, YEAR_W'(lo));
         write_csr(CSR_YEAR_HI, YEAR_W'(hi));
         sender_idles   = (ph != 1 && ph != NUM_PHASES - 1);
         receiver_idles = (ph != 4 && ph != NUM_PHASES - 1);

         // hold the result side off while requests keep coming
         if (ph == PRESSURE_PHASE) begin
            hold_off_req = 1'b1;
            repeat (BURST_REQUESTS) offer_request(random_request(), 1'b0, '0, 1'b0);
         end
         repeat (RAND_PER_PHASE) offer_request(random_request(), 1'b0, '0, 1'b1);
         drain_results();
      end

      if (mismatches == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
design/dtfa_pkg.sv
design/dtfa_if.sv
design/date_time_field_adjuster.sv
tb/tb_date_time_field_adjuster.sv
